FILE: rtl/hll_pkg.sv
package hll_pkg;

  localparam int INDEX_BITS = 10;
  localparam int IDX_W = INDEX_BITS;
  localparam int CNT_W = INDEX_BITS + 1;
  localparam int SUM_W = INDEX_BITS + 33;
  localparam int RANK_W = 6;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic CFG_HASH_SEED = 1'b0;
  localparam logic CFG_KEY_BYTES = 1'b1;

  localparam logic [1:0] RC_SMALL = 2'd0;
  localparam logic [1:0] RC_MIDDLE = 2'd1;
  localparam logic [1:0] RC_LARGE = 2'd2;

  localparam logic [31:0] MM_MUL = 32'h5bd1e995;
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
  localparam logic [63:0] SAT_ALL = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam longint unsigned REG_COUNT = 64'd1 << INDEX_BITS;
  localparam longint unsigned ALPHA_DEN = 64'd10000 * REG_COUNT + 64'd10790;
  localparam longint unsigned ALPHA_Q32 =
    (INDEX_BITS == 4) ? (64'd673 * (64'd1 << 32) + 64'd500) / 64'd1000 :
    (INDEX_BITS == 5) ? (64'd697 * (64'd1 << 32) + 64'd500) / 64'd1000 :
    (INDEX_BITS == 6) ? (64'd709 * (64'd1 << 32) + 64'd500) / 64'd1000 :
    ((64'd7213 * REG_COUNT) * (64'd1 << 32) + ALPHA_DEN / 64'd2) / ALPHA_DEN;
  localparam longint unsigned A_CONST = ALPHA_Q32 * REG_COUNT * REG_COUNT;
  localparam logic [63:0] A_HI = A_CONST >> 48;
  localparam logic [63:0] A_LO = A_CONST << 16;
  localparam logic [63:0] SMALL_LIM = (REG_COUNT * 64'd5) << 15;
  localparam logic [63:0] MID_LIM = (64'd1 << 48) / 64'd30;
  localparam logic [63:0] LARGE_LIM = 64'd1 << 48;
  localparam logic [29:0] TOP_SMALL = 30'(INDEX_BITS) << 24;
  localparam logic [29:0] TOP_LARGE = 30'd48 << 24;
  localparam int SMALL_SH = 40 - INDEX_BITS;
  localparam logic [31:0] W_OR = (32'd1 << (INDEX_BITS - 1)) + 32'd1;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [RANK_W-1:0] wdata;
  } store_req_t;

endpackage

FILE: rtl/hll_mul.sv
module hll_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);
  import hll_pkg::*;

  always_ff @(posedge clk) begin
    prod <= 64'(a) * 64'(b);
  end

endmodule

FILE: rtl/hll_store.sv
module hll_store (
  input  logic                      clk,
  input  hll_pkg::store_req_t       req,
  output logic [hll_pkg::RANK_W-1:0] rdata
);
  import hll_pkg::*;

  logic [RANK_W-1:0] mem [0:(1 << IDX_W)-1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

FILE: rtl/hyperloglog_cardinality_sketch.sv
// Channel   Ports                               Transfer
// config    cfg_write cfg_addr cfg_data         cfg_write high
// input     start busy opcode key               start high, busy low
// result    done estimate range_case            done high, one cycle
// An update runs the hash through one shared 32x32 multiplier, then one read
// and, if the new rank is larger, one write of the rank memory.
// A query and a clear each sweep all 2^INDEX_BITS ranks one per cycle; a query
// then adds a check step, a bit-serial divide and a classify step, and for the
// log cases a normalize, a squaring log and a scaling step.
// After reset a clearing pass over all 2^INDEX_BITS ranks runs with busy high.
// The receiver cannot stall: each result stands for exactly one cycle.
module hyperloglog_cardinality_sketch (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [63:0] key,
  output logic        done,
  output logic [63:0] estimate,
  output logic [1:0]  range_case
);
  import hll_pkg::*;

  typedef enum logic [22:0] {
    S_IDLE   = 23'd1 << 0,
    S_CLR    = 23'd1 << 1,
    S_H_K1   = 23'd1 << 2,
    S_H_K2   = 23'd1 << 3,
    S_H_K3   = 23'd1 << 4,
    S_H_K4   = 23'd1 << 5,
    S_H_TAIL = 23'd1 << 6,
    S_H_T2   = 23'd1 << 7,
    S_H_F1   = 23'd1 << 8,
    S_H_F2   = 23'd1 << 9,
    S_U_RD   = 23'd1 << 10,
    S_U_WR   = 23'd1 << 11,
    S_Q_SUM  = 23'd1 << 12,
    S_Q_LAST = 23'd1 << 13,
    S_DCHK   = 23'd1 << 14,
    S_DIV    = 23'd1 << 15,
    S_CLASS  = 23'd1 << 16,
    S_NORM   = 23'd1 << 17,
    S_SQ1    = 23'd1 << 18,
    S_SQ2    = 23'd1 << 19,
    S_LN1    = 23'd1 << 20,
    S_LN2    = 23'd1 << 21,
    S_SPARE  = 23'd1 << 22
  } state_t;

  state_t state;

  logic [31:0]       seed;
  logic [3:0]        kbytes;
  logic [63:0]       key_r;
  logic [3:0]        len;
  logic [1:0]        nb;
  logic [1:0]        blk;
  logic [31:0]       h;
  logic [31:0]       k;
  logic [IDX_W-1:0]  cnt;
  logic [IDX_W-1:0]  upd_idx;
  logic [RANK_W-1:0] upd_rank;
  logic [CNT_W-1:0]  empty;
  logic [SUM_W-1:0]  sum;
  logic [63:0]       dr;
  logic [63:0]       dlo;
  logic [63:0]       q;
  logic [5:0]        dcnt;
  logic [63:0]       norm;
  logic [5:0]        expo;
  logic [31:0]       lx;
  logic [29:0]       lr;
  logic [4:0]        sq_cnt;
  logic              hi_range;

  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       prod;
  store_req_t        sreq;
  logic [RANK_W-1:0] rdata;

  hll_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));
  hll_store u_store (.clk(clk), .req(sreq), .rdata(rdata));

  logic [3:0]  len_c;
  logic [1:0]  nb_c;
  logic [2:0]  rem;
  logic [31:0] tail_w;
  logic [31:0] tail;
  logic [31:0] kword;
  logic [31:0] k1;
  logic [31:0] hf;
  logic [31:0] w;
  logic [5:0]  lz;
  logic        found;
  logic [32:0] term;
  logic        carry;
  logic [63:0] r2;
  logic        ge;
  logic [63:0] dsum;
  logic [32:0] sq;
  logic [29:0] top;
  logic [29:0] diff;
  logic        last;

  assign busy = (state != S_IDLE);
  assign last = (cnt == {IDX_W{1'b1}});
  assign len_c = (kbytes > 4'd8) ? 4'd8 : kbytes;
  assign nb_c = len_c[3] ? 2'd2 : (len_c[2] ? 2'd1 : 2'd0);
  assign rem = 3'(len - {nb, 2'b00});
  assign tail_w = (nb == 2'd1) ? key_r[63:32] : key_r[31:0];
  assign tail = {8'd0,
                 (rem >= 3'd3) ? tail_w[23:16] : 8'd0,
                 (rem >= 3'd2) ? tail_w[15:8] : 8'd0,
                 tail_w[7:0]};
  assign kword = (blk == 2'd0) ? key_r[31:0] : key_r[63:32];
  assign k1 = prod[31:0] ^ (prod[31:0] >> 24);
  assign hf = prod[31:0] ^ (prod[31:0] >> 15);
  assign w = {hf[31-IDX_W:0], {IDX_W{1'b0}}} | W_OR;
  assign term = (rdata <= RANK_W'(32)) ? (33'd1 << (6'd32 - rdata)) : 33'd0;
  assign dsum = 64'(sum);
  assign carry = dr[63];
  assign r2 = {dr[62:0], dlo[63]};
  assign ge = carry || (r2 >= dsum);
  assign sq = prod[63:31];
  assign top = hi_range ? TOP_LARGE : TOP_SMALL;
  assign diff = (lr >= top) ? 30'd0 : top - lr;

  always_comb begin
    lz = 6'd0;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found) begin
        if (w[i]) begin
          found = 1'b1;
        end else begin
          lz = lz + 6'd1;
        end
      end
    end
  end

  always_comb begin
    mul_b = MM_MUL;
    unique case (state)
      S_H_K1:   mul_a = kword;
      S_H_K2:   mul_a = k1;
      S_H_K3:   mul_a = h;
      S_H_TAIL: mul_a = h ^ tail;
      S_H_F1:   mul_a = h ^ (h >> 13);
      S_SQ1: begin
        mul_a = lx;
        mul_b = lx;
      end
      S_LN1: begin
        mul_a = {2'b00, diff};
        mul_b = LN2_Q32;
      end
      default:  mul_a = h;
    endcase
  end

  always_comb begin
    sreq.we = 1'b0;
    sreq.addr = upd_idx;
    sreq.wdata = upd_rank;
    unique case (state)
      S_CLR: begin
        sreq.we = 1'b1;
        sreq.addr = cnt;
        sreq.wdata = '0;
      end
      S_U_WR:  sreq.we = (rdata < upd_rank);
      S_Q_SUM: sreq.addr = cnt;
      default: sreq.we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cnt <= '0;
      empty <= CNT_W'(REG_COUNT);
      seed <= '0;
      kbytes <= 4'd8;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        unique case (cfg_addr)
          CFG_HASH_SEED: seed <= cfg_data;
          CFG_KEY_BYTES: kbytes <= cfg_data[3:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (opcode)
              OP_UPDATE: begin
                key_r <= key;
                len <= len_c;
                nb <= nb_c;
                blk <= 2'd0;
                h <= seed ^ {28'd0, len_c};
                state <= S_H_K1;
              end
              OP_QUERY: begin
                cnt <= '0;
                sum <= '0;
                state <= S_Q_SUM;
              end
              OP_CLEAR: begin
                cnt <= '0;
                empty <= CNT_W'(REG_COUNT);
                state <= S_CLR;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_CLR: begin
          cnt <= cnt + IDX_W'(1);
          if (last) begin
            state <= S_IDLE;
          end
        end
        S_H_K1: state <= (blk < nb) ? S_H_K2 : S_H_TAIL;
        S_H_K2: state <= S_H_K3;
        S_H_K3: begin
          k <= prod[31:0];
          state <= S_H_K4;
        end
        S_H_K4: begin
          h <= prod[31:0] ^ k;
          blk <= blk + 2'd1;
          state <= S_H_K1;
        end
        S_H_TAIL: state <= (rem != 3'd0) ? S_H_T2 : S_H_F1;
        S_H_T2: begin
          h <= prod[31:0];
          state <= S_H_F1;
        end
        S_H_F1: state <= S_H_F2;
        S_H_F2: begin
          upd_idx <= hf[31 -: IDX_W];
          upd_rank <= lz + 6'd1;
          state <= S_U_RD;
        end
        S_U_RD: state <= S_U_WR;
        S_U_WR: begin
          if (rdata == '0 && empty != '0) begin
            empty <= empty - CNT_W'(1);
          end
          state <= S_IDLE;
        end
        S_Q_SUM: begin
          if (cnt != '0) begin
            sum <= sum + SUM_W'(term);
          end
          cnt <= cnt + IDX_W'(1);
          if (last) begin
            state <= S_Q_LAST;
          end
        end
        S_Q_LAST: begin
          sum <= sum + SUM_W'(term);
          state <= S_DCHK;
        end
        S_DCHK: begin
          dr <= A_HI;
          dlo <= A_LO;
          dcnt <= '0;
          if (sum == '0 || A_HI >= dsum) begin
            q <= SAT_ALL;
            state <= S_CLASS;
          end else begin
            q <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          dr <= ge ? r2 - dsum : r2;
          dlo <= dlo << 1;
          q <= {q[62:0], ge};
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd63) begin
            state <= S_CLASS;
          end
        end
        S_CLASS: begin
          expo <= 6'd63;
          priority if (q <= SMALL_LIM) begin
            range_case <= RC_SMALL;
            hi_range <= 1'b0;
            norm <= 64'(empty);
            if (empty == '0) begin
              estimate <= SAT_ALL;
              done <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_NORM;
            end
          end else if (q >= LARGE_LIM) begin
            range_case <= RC_LARGE;
            estimate <= SAT_ALL;
            done <= 1'b1;
            state <= S_IDLE;
          end else if (q <= MID_LIM) begin
            range_case <= RC_MIDDLE;
            estimate <= q;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            range_case <= RC_LARGE;
            hi_range <= 1'b1;
            norm <= LARGE_LIM - q;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (norm[63]) begin
            lx <= norm[63:32];
            lr <= {expo, 24'd0};
            sq_cnt <= '0;
            state <= S_SQ1;
          end else begin
            norm <= norm << 1;
            expo <= expo - 6'd1;
          end
        end
        S_SQ1: state <= S_SQ2;
        S_SQ2: begin
          if (sq[32]) begin
            lx <= sq[32:1];
            lr <= lr | (30'd1 << (5'd23 - sq_cnt));
          end else begin
            lx <= sq[31:0];
          end
          sq_cnt <= sq_cnt + 5'd1;
          state <= (sq_cnt == 5'd23) ? S_LN1 : S_SQ1;
        end
        S_LN1: state <= S_LN2;
        S_LN2: begin
          estimate <= hi_range ? (prod >> 8) : (prod >> SMALL_SH);
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
